// ===== src/rsbs_pkg.sv =====
// shared types, constants and field layout for the record sequence search block
package rsbs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int IDX_W   = 10;
    localparam int WORD_W  = 16;
    localparam int ADDR_W  = 32;
    localparam int CNT_W   = 11;
    localparam int BYTES_W = 16;
    localparam int PROD_W  = IDX_W + BYTES_W;

    // input tdata layout, lowest bit first
    localparam int IN_IDX_LSB    = 0;
    localparam int IN_WORD_LSB   = IN_IDX_LSB + IDX_W;
    localparam int IN_BASE_LSB   = IN_WORD_LSB + WORD_W;
    localparam int IN_CNT_LSB    = IN_BASE_LSB + ADDR_W;
    localparam int IN_TGT_LSB    = IN_CNT_LSB + CNT_W;
    localparam int IN_USED_W     = IN_TGT_LSB + WORD_W;
    localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int OUT_IDX_LSB   = 0;
    localparam int OUT_ADDR_LSB  = OUT_IDX_LSB + IDX_W;
    localparam int OUT_USED_W    = OUT_ADDR_LSB + ADDR_W;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    localparam int PADDR_W    = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [WORD_W-1:0]  SEQ_MASK_RST  = 16'hFFFF;
    localparam logic [BYTES_W-1:0] REC_BYTES_RST = 16'd32;

    // register index, taken from paddr[2]
    localparam logic REG_SEQ_MASK  = 1'b0;
    localparam logic REG_REC_BYTES = 1'b1;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic start;
        logic probe_rd;
        logic miss;
        logic hit;
        logic narrow;
        logic mul;
        logic add;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic range_ok;
        logic eq;
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== src/rsbs_regs.sv =====
// apb configuration registers: sequence mask and record size
module rsbs_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rsbs_pkg::PADDR_W-1:0]     paddr,
    input  logic [rsbs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rsbs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [rsbs_pkg::WORD_W-1:0]      o_seq_mask,
    output logic [rsbs_pkg::BYTES_W-1:0]     o_record_bytes
);
    import rsbs_pkg::*;

    logic [WORD_W-1:0]  r_seq_mask;
    logic [BYTES_W-1:0] r_record_bytes;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_mask     <= SEQ_MASK_RST;
            r_record_bytes <= REC_BYTES_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_SEQ_MASK:  r_seq_mask     <= pwdata[WORD_W-1:0];
                REG_REC_BYTES: r_record_bytes <= pwdata[BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SEQ_MASK:  prdata = APB_DATA_W'(r_seq_mask);
            REG_REC_BYTES: prdata = APB_DATA_W'(r_record_bytes);
            default:       prdata = '0;
        endcase
    end

    assign o_seq_mask     = r_seq_mask;
    assign o_record_bytes = r_record_bytes;

endmodule

// ===== src/rsbs_ctrl.sv =====
// search sequencer: accepts items and steps the datapath through probes
module rsbs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_mode,
    output logic               o_in_ready,
    input  rsbs_pkg::t_dp_stat i_stat,
    output rsbs_pkg::t_dp_cmd  o_cmd
);
    import rsbs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode == MODE_SEARCH) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_PROBE;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            S_PROBE: begin
                if (i_stat.range_ok) begin
                    o_cmd.probe_rd = 1'b1;
                    n_state        = S_CMP;
                end else begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_CMP: begin
                if (i_stat.eq) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_MUL;
                end else begin
                    o_cmd.narrow = 1'b1;
                    n_state      = S_PROBE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== src/rsbs_dp.sv =====
// search datapath: sequence table, search bounds, address arithmetic, output register
module rsbs_dp #(
    parameter int TABLE_DEPTH = rsbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rsbs_pkg::t_dp_cmd             i_cmd,
    output rsbs_pkg::t_dp_stat            o_stat,
    input  logic [rsbs_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [rsbs_pkg::WORD_W-1:0]   i_seq_word,
    input  logic [rsbs_pkg::ADDR_W-1:0]   i_first_addr,
    input  logic [rsbs_pkg::CNT_W-1:0]    i_record_count,
    input  logic [rsbs_pkg::WORD_W-1:0]   i_target_seq,
    input  logic [rsbs_pkg::WORD_W-1:0]   i_seq_mask,
    input  logic [rsbs_pkg::BYTES_W-1:0]  i_record_bytes,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [rsbs_pkg::IDX_W-1:0]    o_found_index,
    output logic [rsbs_pkg::ADDR_W-1:0]   o_record_addr
);
    import rsbs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [WORD_W-1:0]  r_mem [TABLE_DEPTH];
    logic [WORD_W-1:0]  r_rdata;

    logic [ADDR_W-1:0]  r_base;
    logic [WORD_W-1:0]  r_target;
    logic [CNT_W-1:0]   r_lo;
    logic [CNT_W-1:0]   r_hi;       // exclusive upper bound
    logic [IDX_W-1:0]   r_mid;
    logic [PROD_W-1:0]  r_prod;

    logic               r_found;
    logic [IDX_W-1:0]   r_idx;
    logic [ADDR_W-1:0]  r_addr;

    logic               r_out_valid;
    logic               r_out_found;
    logic [IDX_W-1:0]   r_out_idx;
    logic [ADDR_W-1:0]  r_out_addr;

    logic [CNT_W-1:0]   cnt_sat;
    logic [CNT_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid;
    logic [16:0]        slot_ext;
    logic [16:0]        mid_ext;
    logic               slot_ok;
    logic [WORD_W-1:0]  probe_word;

    assign cnt_sat  = (32'(i_record_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                          : i_record_count;
    // floor((lo + hi_inclusive) / 2) with hi_inclusive = hi - 1
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi} - (CNT_W+1)'(1);
    assign mid      = mid_sum[IDX_W:1];
    assign slot_ext = 17'(i_entry_index);
    assign mid_ext  = 17'(mid);
    assign slot_ok  = 32'(i_entry_index) < TABLE_DEPTH;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && slot_ok) begin
            r_mem[slot_ext[AW-1:0]] <= i_seq_word;
        end
        if (i_cmd.probe_rd) begin
            r_rdata <= r_mem[mid_ext[AW-1:0]];
        end
    end

    assign probe_word = r_rdata & i_seq_mask;

    always_comb begin
        o_stat.range_ok = r_lo < r_hi;
        o_stat.eq       = probe_word == r_target;
        o_stat.out_busy = r_out_valid & ~i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_base   <= i_first_addr;
            r_target <= i_target_seq;
            r_lo     <= '0;
            r_hi     <= cnt_sat;
        end
        if (i_cmd.probe_rd) begin
            r_mid <= mid;
        end
        if (i_cmd.narrow) begin
            if (probe_word > r_target) begin
                r_hi <= CNT_W'(r_mid);
            end else begin
                r_lo <= CNT_W'(r_mid) + CNT_W'(1);
            end
        end
        if (i_cmd.miss) begin
            r_found <= 1'b0;
            r_idx   <= '0;
            r_addr  <= '0;
        end
        if (i_cmd.hit) begin
            r_found <= 1'b1;
            r_idx   <= r_mid;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_idx) * PROD_W'(i_record_bytes);
        end
        if (i_cmd.add) begin
            r_addr <= r_base + ADDR_W'(r_prod);
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_found;
            r_out_idx   <= r_idx;
            r_out_addr  <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_found_index = r_out_idx;
    assign o_record_addr = r_out_addr;

endmodule

// ===== src/record_seq_binary_search.sv =====
// top level of the record sequence binary search block
// A load item (tuser 0) writes one 16-bit word into the sequence table;
// it gives no result. A search item (tuser 1) runs a binary search over the first
// min(record_count, TABLE_DEPTH) entries, comparing each masked word with the target, and
// gives one result: found in tuser, the index and first_addr + index * record_bytes in tdata
// (both zero on a miss). Each probe consists of a registered read of the
// single-port table followed by a compare. The result waits in an output register, and the
// next item is accepted while it waits. The table has no reset: an entry must be loaded
// before a search can reach it.
module record_seq_binary_search #(
    parameter int TABLE_DEPTH = rsbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // entry_index, seq_word, first_addr, record_count, target_seq, zero fill
    input  logic [rsbs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // mode
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // found_index, record_addr, zero fill
    output logic [rsbs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // found
    output logic                              m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rsbs_pkg::PADDR_W-1:0]      paddr,
    input  logic [rsbs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rsbs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import rsbs_pkg::*;

    logic [WORD_W-1:0]  seq_mask;
    logic [BYTES_W-1:0] record_bytes;
    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [IDX_W-1:0]   found_index;
    logic [ADDR_W-1:0]  record_addr;

    rsbs_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_seq_mask     (seq_mask),
        .o_record_bytes (record_bytes)
    );

    rsbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rsbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_entry_index  (s_axis_tdata[IN_IDX_LSB +: IDX_W]),
        .i_seq_word     (s_axis_tdata[IN_WORD_LSB +: WORD_W]),
        .i_first_addr   (s_axis_tdata[IN_BASE_LSB +: ADDR_W]),
        .i_record_count (s_axis_tdata[IN_CNT_LSB +: CNT_W]),
        .i_target_seq   (s_axis_tdata[IN_TGT_LSB +: WORD_W]),
        .i_seq_mask     (seq_mask),
        .i_record_bytes (record_bytes),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_found        (m_axis_tuser),
        .o_found_index  (found_index),
        .o_record_addr  (record_addr)
    );

    assign m_axis_tdata = OUT_TDATA_W'({record_addr, found_index});

endmodule

// ===== src/rsbs_check.sv =====
// port-level checks for the record sequence search block, bound to the top level
module rsbs_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tuser,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [rsbs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready
);
    import rsbs_pkg::*;

    // nothing comes out straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled item keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a miss reports zero index and zero address
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss with nonzero index or address");

    // a search keeps the input closed for at least the first probe
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_SEARCH |=> !s_axis_tready)
        else $error("input open during search");

    // a load item gives no result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_LOAD && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result after load item");

endmodule

bind record_seq_binary_search rsbs_check u_rsbs_check (.*);
